### rtl/deq_pkg.sv
// deq_pkg: shared constants, operation and status codes, cell control struct
// for the double-ended queue. No dependencies.

package deq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STAT_W   = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST       = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic shift_r;    // push front: everything moves one cell toward the back
    logic shift_l;    // pop front: everything moves one cell toward the front
    logic ins_back;   // push back: first empty cell takes the value
    logic drop_back;  // pop back: tail cell goes empty
    logic rotate;     // listing: head wraps around to the tail
  } cell_ctrl_t;

endpackage

### rtl/deq_in_if.sv
// deq_in_if: request channel of the double-ended queue (operation and value).
// Depends on deq_pkg.

interface deq_in_if import deq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic        [KIND_W-1:0] kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

### rtl/deq_out_if.sv
// deq_out_if: result channel of the double-ended queue (status, data, last).
// Depends on deq_pkg.

interface deq_out_if import deq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic        [STAT_W-1:0] status;
  logic signed [DATA_W-1:0] data;
  logic                     last;

  modport source (output valid, status, data, last, input ready);
  modport sink   (input valid, status, data, last, output ready);
endinterface

### rtl/deq_cell.sv
// deq_cell: one storage cell of the queue chain, holding an entry and its
// valid bit and trading data with both neighbors. Depends on deq_pkg.

module deq_cell import deq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  input  logic                     prev_valid_i,
  input  logic signed [DATA_W-1:0] prev_data_i,
  input  logic                     next_valid_i,
  input  logic signed [DATA_W-1:0] next_data_i,
  input  logic signed [DATA_W-1:0] head_data_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic                     tail_o
);

  logic                     valid_q, valid_d;
  logic signed [DATA_W-1:0] data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.shift_r) begin
      valid_d = prev_valid_i;
      data_d  = prev_data_i;
    end else if (ctrl_i.shift_l) begin
      valid_d = next_valid_i;
      data_d  = next_data_i;
    end else if (ctrl_i.ins_back && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      data_d  = push_value_i;
    end else if (ctrl_i.drop_back && valid_q && !next_valid_i) begin
      valid_d = 1'b0;
    end else if (ctrl_i.rotate && valid_q) begin
      // each cell takes its successor's entry; the tail cell picks up the old head
      data_d = next_valid_i ? next_data_i : head_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign tail_o  = valid_q && !next_valid_i;

endmodule

### rtl/double_ended_queue.sv
// double_ended_queue: top level, a chain of deq_cell instances with a small
// controller and a registered result stage. Depends on deq_pkg, deq_in_if,
// deq_out_if and deq_cell.
//
//   channel  dir  modport            beat contents
//   in_i     in   deq_in_if.sink     kind, value
//   out_o    out  deq_out_if.source  status, data, last
//
// push and pop: one beat per cycle while the result is not stalled, result in
// the cycle after acceptance. listing: the list state entered on acceptance
// sends one result per cycle while not stalled, one per stored entry, front to
// back, as the chain rotates once through its cells; the next request is taken in idle.
// reset clears the valid bits and count; entry data is not reset.
// a stalled result holds the output register; the next request is taken in
// the cycle the held result leaves.

module double_ended_queue import deq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_in_if.sink    in_i,
  deq_out_if.source out_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic                     state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         remain_q, remain_d;
  logic                     out_valid_q, out_valid_d;
  logic [STAT_W-1:0]        out_status_q, out_status_d;
  logic signed [DATA_W-1:0] out_data_q, out_data_d;
  logic                     out_last_q, out_last_d;

  cell_ctrl_t               ctrl;
  logic                     out_free;
  logic                     accept;
  logic                     is_full;
  logic                     is_empty;
  logic signed [DATA_W-1:0] tail_data;

  logic [CAPACITY-1:0]      cell_valid;
  logic [CAPACITY-1:0]      cell_tail;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];

  // cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                     pv, nv;
    logic signed [DATA_W-1:0] pd, nd;
    if (g == 0) begin : g_first
      assign pv = 1'b1;
      assign pd = in_i.value;
    end else begin : g_mid
      assign pv = cell_valid[g-1];
      assign pd = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign nv = 1'b0;
      assign nd = '0;
    end else begin : g_inner
      assign nv = cell_valid[g+1];
      assign nd = cell_data[g+1];
    end
    deq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .push_value_i (in_i.value),
      .prev_valid_i (pv),
      .prev_data_i  (pd),
      .next_valid_i (nv),
      .next_data_i  (nd),
      .head_data_i  (cell_data[0]),
      .valid_o      (cell_valid[g]),
      .data_o       (cell_data[g]),
      .tail_o       (cell_tail[g])
    );
  end

  always_comb begin
    tail_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_data = tail_data | (cell_data[i] & {DATA_W{cell_tail[i]}});
    end
  end

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept   = in_i.valid && in_i.ready;
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  always_comb begin
    ctrl         = '0;
    state_d      = state_q;
    count_d      = count_q;
    remain_d     = remain_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;

    if (accept) begin
      out_valid_d  = 1'b1;
      out_status_d = STAT_OK;
      out_data_d   = '0;
      out_last_d   = 1'b1;
      case (in_i.kind)
        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
          if (is_full) begin
            out_status_d = STAT_FULL;
          end else begin
            ctrl.shift_r  = (in_i.kind == KIND_PUSH_FRONT);
            ctrl.ins_back = (in_i.kind == KIND_PUSH_BACK);
            count_d       = count_q + CNT_W'(1);
          end
        end
        KIND_POP_FRONT, KIND_POP_BACK: begin
          if (is_empty) begin
            out_status_d = STAT_EMPTY;
          end else begin
            ctrl.shift_l   = (in_i.kind == KIND_POP_FRONT);
            ctrl.drop_back = (in_i.kind == KIND_POP_BACK);
            out_data_d     = (in_i.kind == KIND_POP_FRONT) ? cell_data[0] : tail_data;
            count_d        = count_q - CNT_W'(1);
          end
        end
        KIND_LIST: begin
          if (is_empty) begin
            out_status_d = STAT_EMPTY;
          end else begin
            // results stream from the list state
            out_valid_d = 1'b0;
            remain_d    = count_q;
            state_d     = ST_LIST;
          end
        end
        default: begin
          out_valid_d = 1'b0;
        end
      endcase
    end else if (state_q == ST_LIST && out_free) begin
      ctrl.rotate  = 1'b1;
      out_valid_d  = 1'b1;
      out_status_d = STAT_OK;
      out_data_d   = cell_data[0];
      out_last_d   = (remain_q == CNT_W'(1));
      remain_d     = remain_q - CNT_W'(1);
      if (remain_q == CNT_W'(1)) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.data   = out_data_q;
  assign out_o.last   = out_last_q;

  // count and cell valid bits agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("count does not match occupied cells");

  // occupied cells form one run starting at the head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & (cell_valid + CAPACITY'(1))) == '0)
    else $error("gap in cell chain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // a non-final result only comes from a listing still in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> state_q == ST_LIST && remain_q != '0)
    else $error("non-final result outside listing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LIST |-> remain_q != '0 && remain_q <= count_q)
    else $error("listing counter out of range");

endmodule
